### rtl/lpr_pkg.sv
// Package with the shared constants and command codes of the line pixel rasterizer.
`timescale 1ns / 1ps

package lpr_pkg;

	localparam int COORD_WIDTH_DEF = 12;
	localparam int COLOR_WIDTH_DEF = 24;

	typedef enum logic {
		CMD_LOAD = 1'b0,
		CMD_STEP = 1'b1
	} cmd_t;

endpackage

### rtl/line_pixel_rasterizer.sv
// Line pixel rasterizer: a load transaction takes two endpoints and a color and returns the end
// pixel in the next cycle. Each step transaction returns the next pixel from the start toward the
// end, and the pixel before the end one carries last. A step finds the minor coordinate with a
// radix-2 multiply-divide that takes one bit of the major offset per cycle, after which a finish
// state registers the pixel. A step with no active line is taken and returns nothing. The block
// holds one transaction at a time: a new one is accepted only after the previous pixel has been
// taken.
`timescale 1ns / 1ps

module line_pixel_rasterizer #(
	parameter int COORD_WIDTH = lpr_pkg::COORD_WIDTH_DEF,
	parameter int COLOR_WIDTH = lpr_pkg::COLOR_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  lpr_pkg::cmd_t          command,
	input  logic [COORD_WIDTH-1:0] start_x,
	input  logic [COORD_WIDTH-1:0] start_y,
	input  logic [COORD_WIDTH-1:0] end_x,
	input  logic [COORD_WIDTH-1:0] end_y,
	input  logic [COLOR_WIDTH-1:0] color,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [COORD_WIDTH-1:0] pixel_x,
	output logic [COORD_WIDTH-1:0] pixel_y,
	output logic [COLOR_WIDTH-1:0] pixel_color,
	output logic                   last
);

	import lpr_pkg::*;

	localparam int W     = COORD_WIDTH;
	localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t state_q;

	// Line held since the last load, already sorted into major and minor axis.
	logic [W-1:0]           maj_s_q, maj_e_q, min_s_q;
	logic [W-1:0]           abs_dmin_q, abs_dmaj_q;
	logic                   dmin_neg_q, dmaj_neg_q;
	logic                   major_is_y_q;
	logic [W-1:0]           cursor_q;
	logic                   line_active_q;
	logic [COLOR_WIDTH-1:0] color_q;

	// Serial multiply-divide state.
	logic [W-1:0]     k_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [CNT_W-1:0] cnt_q;

	logic [COORD_WIDTH-1:0] pixel_x_q, pixel_y_q;
	logic [COLOR_WIDTH-1:0] pixel_color_q;
	logic                   last_q;

	// Load decode.
	logic signed [W:0] dx, dy;
	logic [W-1:0]      adx, ady;
	logic              ld_major_y, ld_same;

	always_comb begin
		dx = $signed({1'b0, end_x}) - $signed({1'b0, start_x});
		dy = $signed({1'b0, end_y}) - $signed({1'b0, start_y});
		adx = dx[W] ? W'(-dx) : dx[W-1:0];
		ady = dy[W] ? W'(-dy) : dy[W-1:0];
		ld_major_y = adx < ady;
		ld_same = (end_x == start_x) && (end_y == start_y);
	end

	// One radix-2 step: remainder doubles, the minor delta enters when the offset bit is set,
	// and since that sum stays below three times the divisor the quotient digit is 0, 1 or 2.
	logic [W+1:0] trial;
	logic [W+1:0] div1, div2;
	logic [W-1:0] rem_n;
	logic [1:0]   digit;
	logic [W-1:0] quo_n;

	always_comb begin
		div1  = {2'b00, abs_dmaj_q};
		div2  = {1'b0, abs_dmaj_q, 1'b0};
		trial = {1'b0, rem_q, 1'b0} + (k_q[W-1] ? {2'b00, abs_dmin_q} : '0);
		if (trial >= div2) begin
			rem_n = W'(trial - div2);
			digit = 2'd2;
		end else if (trial >= div1) begin
			rem_n = W'(trial - div1);
			digit = 2'd1;
		end else begin
			rem_n = trial[W-1:0];
			digit = 2'd0;
		end
		quo_n = W'({quo_q, 1'b0}) + W'(digit);
	end

	// Step finish.
	logic [W-1:0] minor, next_cursor, k_start;
	logic         step_last;

	always_comb begin
		minor       = dmin_neg_q ? (min_s_q - quo_q) : (min_s_q + quo_q);
		next_cursor = dmaj_neg_q ? (cursor_q - W'(1)) : (cursor_q + W'(1));
		step_last   = next_cursor == maj_e_q;
		k_start     = dmaj_neg_q ? (maj_s_q - cursor_q) : (cursor_q - maj_s_q);
	end

	assign in_ready    = state_q == ST_IDLE;
	assign out_valid   = state_q == ST_OUT;
	assign pixel_x     = pixel_x_q;
	assign pixel_y     = pixel_y_q;
	assign pixel_color = pixel_color_q;
	assign last        = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			maj_s_q       <= '0;
			maj_e_q       <= '0;
			min_s_q       <= '0;
			abs_dmin_q    <= '0;
			abs_dmaj_q    <= '0;
			dmin_neg_q    <= 1'b0;
			dmaj_neg_q    <= 1'b0;
			major_is_y_q  <= 1'b0;
			cursor_q      <= '0;
			line_active_q <= 1'b0;
			color_q       <= '0;
			k_q           <= '0;
			rem_q         <= '0;
			quo_q         <= '0;
			cnt_q         <= '0;
			pixel_x_q     <= '0;
			pixel_y_q     <= '0;
			pixel_color_q <= '0;
			last_q        <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						if (command == CMD_LOAD) begin
							major_is_y_q  <= ld_major_y;
							maj_s_q       <= ld_major_y ? start_y : start_x;
							maj_e_q       <= ld_major_y ? end_y : end_x;
							min_s_q       <= ld_major_y ? start_x : start_y;
							abs_dmaj_q    <= ld_major_y ? ady : adx;
							abs_dmin_q    <= ld_major_y ? adx : ady;
							dmaj_neg_q    <= ld_major_y ? dy[W] : dx[W];
							dmin_neg_q    <= ld_major_y ? dx[W] : dy[W];
							cursor_q      <= ld_major_y ? start_y : start_x;
							line_active_q <= !ld_same;
							color_q       <= color;
							pixel_x_q     <= end_x;
							pixel_y_q     <= end_y;
							pixel_color_q <= color;
							last_q        <= ld_same;
							state_q       <= ST_OUT;
						end else if (line_active_q) begin
							if (abs_dmaj_q == '0) begin
								line_active_q <= 1'b0;
							end else begin
								k_q     <= k_start;
								rem_q   <= '0;
								quo_q   <= '0;
								cnt_q   <= CNT_W'(W - 1);
								state_q <= ST_CALC;
							end
						end
					end
				end
				ST_CALC: begin
					k_q   <= {k_q[W-2:0], 1'b0};
					rem_q <= rem_n;
					quo_q <= quo_n;
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					pixel_x_q     <= major_is_y_q ? minor : cursor_q;
					pixel_y_q     <= major_is_y_q ? cursor_q : minor;
					pixel_color_q <= color_q;
					last_q        <= step_last;
					cursor_q      <= next_cursor;
					if (step_last) begin
						line_active_q <= 1'b0;
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A pixel waiting on the output never overlaps with taking a new transaction.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input accepted while a pixel is pending");

	// A load returns its end pixel in the next cycle.
	a_load_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && command == CMD_LOAD) |=> out_valid)
		else $error("load did not return its end pixel");

	// The remainder of the serial divider stays below the divisor.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC) |-> (rem_q < abs_dmaj_q))
		else $error("divider remainder out of range");

	// The final pixel of a line leaves no line active.
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |-> !line_active_q)
		else $error("line still active after its final pixel");

endmodule

### tb/testbench.sv
// Self-checking testbench for the line pixel rasterizer with a built-in pixel predictor.
`timescale 1ns / 1ps

module testbench;
	import lpr_pkg::*;

	typedef struct packed {
		logic [11:0] x;
		logic [11:0] y;
		logic [23:0] color;
		logic        last;
	} pixel_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	cmd_t        command;
	logic [11:0] start_x;
	logic [11:0] start_y;
	logic [11:0] end_x;
	logic [11:0] end_y;
	logic [23:0] color;
	logic        out_valid;
	logic        out_ready;
	logic [11:0] pixel_x;
	logic [11:0] pixel_y;
	logic [23:0] pixel_color;
	logic        last;

	// Line held by the predictor.
	logic [11:0] ln_sx = '0;
	logic [11:0] ln_sy = '0;
	logic [11:0] ln_ex = '0;
	logic [11:0] ln_ey = '0;
	logic [23:0] ln_color = '0;
	logic        ln_major_y = 1'b0;
	logic [11:0] ln_cursor = '0;
	logic        line_on = 1'b0;

	pixel_t pending_pixels[$];
	int     mismatches = 0;
	int     tx_gap_max = 0;
	int     rx_gap_max = 0;
	int     rx_hold_cycles = 0;

	line_pixel_rasterizer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.start_x(start_x),
		.start_y(start_y),
		.end_x(end_x),
		.end_y(end_y),
		.color(color),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_color(pixel_color),
		.last(last)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int iabs(input int v);
		return (v < 0) ? -v : v;
	endfunction

	// Advances the predicted line by one transaction; returns 1 when a pixel comes out.
	function automatic bit rasterize_next(input cmd_t cmd, input logic [11:0] sx, sy, ex, ey,
			input logic [23:0] col, output pixel_t px);
		int dx, dy, maj_s, maj_e, min_s, dmaj, dmin, q, minor, nxt;
		px = '0;
		if (cmd == CMD_LOAD) begin
			ln_sx = sx;
			ln_sy = sy;
			ln_ex = ex;
			ln_ey = ey;
			ln_color = col;
			dx = int'(ex) - int'(sx);
			dy = int'(ey) - int'(sy);
			ln_major_y = iabs(dx) < iabs(dy);
			ln_cursor = ln_major_y ? sy : sx;
			line_on = (dx != 0) || (dy != 0);
			px.x = ex;
			px.y = ey;
			px.color = col;
			px.last = !line_on;
			return 1'b1;
		end
		if (!line_on)
			return 1'b0;
		if (ln_major_y) begin
			maj_s = int'(ln_sy);
			maj_e = int'(ln_ey);
			min_s = int'(ln_sx);
			dmin = int'(ln_ex) - int'(ln_sx);
		end else begin
			maj_s = int'(ln_sx);
			maj_e = int'(ln_ex);
			min_s = int'(ln_sy);
			dmin = int'(ln_ey) - int'(ln_sy);
		end
		dmaj = maj_e - maj_s;
		if (dmaj == 0) begin
			line_on = 1'b0;
			return 1'b0;
		end
		q = iabs(dmin) * iabs(int'(ln_cursor) - maj_s) / iabs(dmaj);
		minor = (dmin < 0) ? min_s - q : min_s + q;
		nxt = int'(ln_cursor) + ((dmaj < 0) ? -1 : 1);
		px.color = ln_color;
		px.last = (nxt == maj_e);
		if (ln_major_y) begin
			px.x = minor[11:0];
			px.y = ln_cursor;
		end else begin
			px.x = ln_cursor;
			px.y = minor[11:0];
		end
		if (nxt == maj_e)
			line_on = 1'b0;
		ln_cursor = nxt[11:0];
		return 1'b1;
	endfunction

	function automatic logic [11:0] near(input logic [11:0] c, input int span);
		int v;
		v = int'(c) + $urandom_range(0, 2 * span) - span;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[11:0];
	endfunction

	// Offers one transaction and waits for the block to take it.
	task automatic send_item(input cmd_t cmd, input logic [11:0] sx, sy, ex, ey,
			input logic [23:0] col);
		int gap;
		pixel_t px;
		gap = $urandom_range(0, tx_gap_max);
		@(negedge clk);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		command = cmd;
		start_x = sx;
		start_y = sy;
		end_x = ex;
		end_y = ey;
		color = col;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		if (rasterize_next(cmd, sx, sy, ex, ey, col, px))
			pending_pixels.push_back(px);
	endtask

	task automatic send_step();
		send_item(CMD_STEP, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
			12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
			24'($urandom_range(0, 24'hFFFFFF)));
	endtask

	task automatic report_field(input string name, input logic [23:0] want, got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Receiver: takes pixels with random stalls and checks each against the oldest prediction.
	initial begin
		int stall;
		pixel_t want;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = (rx_hold_cycles > 0) ? rx_hold_cycles : $urandom_range(0, rx_gap_max);
			rx_hold_cycles = 0;
			out_ready = 1'b0;
			repeat (stall) @(negedge clk);
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel x=%0h y=%0h color=%0h last=%0b", $time,
					pixel_x, pixel_y, pixel_color, last);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				report_field("pixel_x", 24'(want.x), 24'(pixel_x));
				report_field("pixel_y", 24'(want.y), 24'(pixel_y));
				report_field("pixel_color", want.color, pixel_color);
				report_field("last", 24'(want.last), 24'(last));
			end
		end
	end

	task automatic test_directed();
		tx_gap_max = 3;
		rx_gap_max = 3;
		// A step before any line is loaded gives nothing.
		send_item(CMD_STEP, 0, 0, 0, 0, 0);
		// Single-pixel lines at both corners and both color extremes.
		send_item(CMD_LOAD, 0, 0, 0, 0, 24'h000000);
		send_item(CMD_STEP, 0, 0, 0, 0, 0);
		send_item(CMD_LOAD, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 24'hFFFFFF);
		// Full-range diagonals, each dropped by the next load.
		send_item(CMD_LOAD, 0, 0, 12'hFFF, 12'hFFF, 24'hA5A5A5);
		send_step();
		send_step();
		send_item(CMD_LOAD, 12'hFFF, 0, 0, 12'hFFF, 24'h5A5A5A);
		send_step();
		send_step();
		// Horizontal line walked to the end, then one step too many.
		send_item(CMD_LOAD, 10, 10, 13, 10, 24'h123456);
		repeat (4) send_step();
		// Vertical line walking upward.
		send_item(CMD_LOAD, 5, 9, 5, 5, 24'h654321);
		repeat (4) send_step();
		// Equal deltas of opposite sign: x stays the major axis.
		send_item(CMD_LOAD, 7, 3, 4, 6, 24'h00FF00);
		repeat (3) send_step();
	endtask

	// Mostly whole lines with random content, some cut short, plus loose transactions.
	task automatic test_random_lines(input int n_items, input int tx_max, input int rx_max);
		int sent, roll, span, cap, steps;
		logic [11:0] sx, sy, ex, ey;
		tx_gap_max = tx_max;
		rx_gap_max = rx_max;
		sent = 0;
		while (sent < n_items) begin
			roll = $urandom_range(0, 99);
			if (roll < 10) begin
				if (roll < 5)
					send_step();
				else
					send_item(CMD_LOAD, 12'($urandom_range(0, 4095)),
						12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
						12'($urandom_range(0, 4095)), 24'($urandom_range(0, 24'hFFFFFF)));
				sent++;
			end else begin
				span = (roll < 22) ? 4095 : ((roll < 40) ? 3 : 24);
				sx = 12'($urandom_range(0, 4095));
				sy = 12'($urandom_range(0, 4095));
				if (roll < 14) begin
					ex = sx;
					ey = sy;
				end else begin
					ex = near(sx, span);
					ey = near(sy, span);
				end
				send_item(CMD_LOAD, sx, sy, ex, ey, 24'($urandom_range(0, 24'hFFFFFF)));
				sent++;
				cap = (span > 24 || roll % 7 == 0) ? $urandom_range(0, 6) : 64;
				steps = 0;
				while (line_on && steps < cap) begin
					send_step();
					steps++;
					sent++;
				end
				if (roll % 5 == 0)
					send_step();
			end
		end
	endtask

	// The receiver holds off while steps keep coming, so the block must stall its input.
	task automatic test_output_stall();
		tx_gap_max = 0;
		rx_gap_max = 0;
		send_item(CMD_LOAD, 100, 100, 130, 110, 24'hC0FFEE);
		rx_hold_cycles = 400;
		repeat (12) send_step();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_LOAD;
		start_x = '0;
		start_y = '0;
		end_x = '0;
		end_y = '0;
		color = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random_lines(500, 12, 12);
		test_output_stall();
		test_random_lines(250, 0, 0);
		test_random_lines(200, 12, 0);
		test_random_lines(200, 0, 12);

		@(negedge clk);
		in_valid = 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#1_500_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
